### rtl/core/fpn_pkg.sv
// fpn_pkg: widths, codes and small helper functions of the fractal Perlin noise core.
// Used by the noise core top level, its port checker and the testbench.
// No dependencies.
package fpn_pkg;

  // Field widths
  localparam int COORD_W = 32;   // Q16.16 coordinates
  localparam int FREQ_W  = 24;   // Q8.16 frequency
  localparam int AMP_W   = 16;   // Q4.12 amplitude and Q0.16 / Q4.12 factors
  localparam int FRAC_W  = 16;   // lattice fraction, Q0.16
  localparam int NOISE_W = 16;   // Q2.14 result
  localparam int PERM_W  = 8;    // permutation entry
  localparam int ACT_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Internal datapath widths
  localparam int GRAD_W = 20;            // gradient dot products and lerps
  localparam int DIFF_W = GRAD_W + 1;    // lerp operand difference
  localparam int FADE_W = 18;            // fade value and signed fraction
  localparam int FB_W   = 21;            // fade polynomial terms
  localparam int MA_W   = 33;            // shared multiplier operand A
  localparam int MB_W   = 25;            // shared multiplier operand B
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = COORD_W + 3;   // coordinate sums before saturation

  // Fade polynomial 6t^5 - 15t^4 + 10t^3
  localparam int ONE_Q16 = 65536;
  localparam int FADE_C1 = 6;
  localparam int FADE_C2 = 15;
  localparam int FADE_C3 = 10;

  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = {1'b0, {(NOISE_W-1){1'b1}}};
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = {1'b1, {(NOISE_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Request kinds
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FRACTAL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WARP    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_AMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LACUN     = 3'd4;

  // Gradient directions selected by the low three hash bits
  localparam logic [2:0] GRD_PP = 3'd0;  // x + y
  localparam logic [2:0] GRD_NP = 3'd1;  // -x + y
  localparam logic [2:0] GRD_PN = 3'd2;  // x - y
  localparam logic [2:0] GRD_NN = 3'd3;  // -x - y
  localparam logic [2:0] GRD_PX = 3'd4;  // x
  localparam logic [2:0] GRD_NX = 3'd5;  // -x
  localparam logic [2:0] GRD_PY = 3'd6;  // y

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [GRAD_W-1:0]  grad_t;

  // Gradient dot product of one lattice corner
  function automatic grad_t grad_dot(input logic [2:0] h,
                                     input logic signed [FADE_W-1:0] gx,
                                     input logic signed [FADE_W-1:0] gy);
    grad_t xe;
    grad_t ye;
    grad_t r;
    xe = GRAD_W'(gx);
    ye = GRAD_W'(gy);
    case (h)
      GRD_PP:  r = xe + ye;
      GRD_NP:  r = ye - xe;
      GRD_PN:  r = xe - ye;
      GRD_NN:  r = -xe - ye;
      GRD_PX:  r = xe;
      GRD_NX:  r = -xe;
      GRD_PY:  r = ye;
      default: r = -ye;
    endcase
    return r;
  endfunction

  // Clamp a widened coordinate sum to the signed Q16.16 range
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    coord_t r;
    top = v[SUM_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = COORD_MIN;
    end else begin
      r = COORD_MAX;
    end
    return r;
  endfunction

endpackage

### rtl/core/fpn_ram.sv
// fpn_ram: generic single-write, single-read synchronous RAM with registered read data.
// Holds the permutation table of the noise core; no package dependency.
module fpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  assign rdata = rd_r;

endmodule

### rtl/core/fractal_perlin_noise_2d.sv
// fractal_perlin_noise_2d: fixed-point 2D gradient noise, fractal sum and domain warp.
// Uses fpn_pkg (widths, codes, helpers) and fpn_ram (permutation table).
//
// Channel | Direction | Fields
// in_     | request   | tuser: action; tdata: index, value, x, y, strength, four offsets
// out_    | result    | tdata: noise_value; tuser: write_ack
// cfg_    | write     | cfg_idx selects octaves, amplitude, frequency, persistence, lacunarity
//
// One request at a time; a table write or unused action goes straight to the hand-over state
// S_PUT. Fractal noise, N = min(octave_count, MAX_OCTAVES), runs 19 steps per octave on one
// shared 33x25 multiplier and the table read port, then a 15-step restoring divider (skipped
// when the summed amplitude is zero). Warped noise runs three fractal passes and three
// displacement states. Reset idles the sequencer and empties the result register; the table
// is not cleared. A stalled result holds in the output register while the next request is
// taken and computed.
module fractal_perlin_noise_2d import fpn_pkg::*; #(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ACT_W-1:0]      in_tuser,   // [1:0] action
  // [7:0] table_index, [15:8] table_value, [47:16] coord_x, [79:48] coord_y,
  // [111:80] warp_strength, [143:112] warp_x_off_x, [175:144] warp_y_off_x,
  // [207:176] warp_x_off_y, [239:208] warp_y_off_y
  input  logic [239:0]          in_tdata,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [NOISE_W-1:0]    out_tdata,  // [15:0] noise_value
  output logic [0:0]            out_tuser,  // [0] write_ack
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW     = $clog2(TABLE_SIZE);
  localparam int OCW    = $clog2(MAX_OCTAVES + 1);
  localparam int TOT_W  = AMP_W + OCW;
  localparam int ACC_W  = GRAD_W + AMP_W + 1 + OCW;
  localparam int Q_BITS = NOISE_W - 1;
  localparam int CNT_W  = $clog2(Q_BITS);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_OCT  = 4'd2;
  localparam logic [3:0] S_DIV0 = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_W1   = 4'd6;
  localparam logic [3:0] S_W2   = 4'd7;
  localparam logic [3:0] S_W3   = 4'd8;
  localparam logic [3:0] S_PUT  = 4'd9;

  // Octave steps
  localparam logic [4:0] K_CX  = 5'd0;
  localparam logic [4:0] K_CY  = 5'd1;
  localparam logic [4:0] K_FU1 = 5'd2;
  localparam logic [4:0] K_FU2 = 5'd3;
  localparam logic [4:0] K_FU3 = 5'd4;
  localparam logic [4:0] K_FU4 = 5'd5;
  localparam logic [4:0] K_FV1 = 5'd6;
  localparam logic [4:0] K_FV2 = 5'd7;
  localparam logic [4:0] K_FV3 = 5'd8;
  localparam logic [4:0] K_FV4 = 5'd9;
  localparam logic [4:0] K_B0  = 5'd10;
  localparam logic [4:0] K_B1  = 5'd11;
  localparam logic [4:0] K_B2  = 5'd12;
  localparam logic [4:0] K_B3  = 5'd13;
  localparam logic [4:0] K_BN  = 5'd14;
  localparam logic [4:0] K_NA  = 5'd15;
  localparam logic [4:0] K_AC  = 5'd16;
  localparam logic [4:0] K_AM  = 5'd17;
  localparam logic [4:0] K_FQ  = 5'd18;

  // Fractal pass being run
  localparam logic [1:0] PH_OX  = 2'd0;
  localparam logic [1:0] PH_OY  = 2'd1;
  localparam logic [1:0] PH_OUT = 2'd2;

  // Control registers
  logic [3:0]       state_r, state_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [1:0]       ph_r;
  logic [OCW-1:0]   oct_r;
  logic [OCW-1:0]   noct_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_tvalid_r;

  // Configuration registers
  logic [3:0]        cfg_oct_r;
  logic [AMP_W-1:0]  cfg_amp_r;
  logic [FREQ_W-1:0] cfg_freq_r;
  logic [AMP_W-1:0]  cfg_pers_r;
  logic [AMP_W-1:0]  cfg_lac_r;

  // Payload registers
  coord_t x_r, y_r, ws_r, wxy_r, wyy_r, cx_r, cy_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [FRAC_W-1:0]        fx_r, fy_r;
  logic [IW-1:0]            ix_r, iy_r, px0_r, px1_r;
  logic signed [FB_W-1:0]   fb_r;
  logic signed [FADE_W-1:0] u_r, v_r;
  grad_t                    g_aa_r, g_ab_r, g_ba_r, g_bb_r, r0_r, r1_r, n_r;
  logic [AMP_W-1:0]         amp_r;
  logic [FREQ_W-1:0]        freq_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [TOT_W-1:0]         tot_r;
  logic [ACC_W-1:0]         rem_r, dsh_r;
  logic [Q_BITS-1:0]        q_r;
  logic                     neg_r, ovf_r;
  logic signed [NOISE_W-1:0] ox_r, oy_r, res_r, out_noise_r;
  logic                     ack_r, out_ack_r;

  // Request fields
  logic [ACT_W-1:0]  in_act;
  logic [PERM_W-1:0] in_idx, in_val;
  coord_t in_x, in_y, in_ws, in_wxx, in_wyx, in_wxy, in_wyy;
  logic req_acc;

  assign in_act = in_tuser;
  assign in_idx = in_tdata[7:0];
  assign in_val = in_tdata[15:8];
  assign in_x   = in_tdata[47:16];
  assign in_y   = in_tdata[79:48];
  assign in_ws  = in_tdata[111:80];
  assign in_wxx = in_tdata[143:112];
  assign in_wyx = in_tdata[175:144];
  assign in_wxy = in_tdata[207:176];
  assign in_wyy = in_tdata[239:208];

  assign in_tready = (state_r == S_IDLE);
  assign req_acc   = in_tvalid && in_tready;

  // Permutation table
  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  logic [PERM_W-1:0] ram_rdata;
  logic [IW-1:0]     rd_idx;

  assign ram_we = req_acc && (in_act == ACT_WRITE) && (32'(in_idx) < TABLE_SIZE);
  assign rd_idx = IW'(ram_rdata);

  fpn_ram #(
    .WIDTH (PERM_W),
    .DEPTH (TABLE_SIZE)
  ) u_perm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(in_idx)),
    .wdata (in_val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Signed fractions of the corners, fade input and first fade term
  logic signed [FADE_W-1:0] fx0, fx1, fy0, fy1;
  logic [FRAC_W-1:0]        ft;
  logic signed [FB_W-1:0]   fa;
  logic                     fade_u;

  assign fx0    = FADE_W'({2'b00, fx_r});
  assign fx1    = fx0 - FADE_W'(ONE_Q16);
  assign fy0    = FADE_W'({2'b00, fy_r});
  assign fy1    = fy0 - FADE_W'(ONE_Q16);
  assign fade_u = (step_r == K_FU1) || (step_r == K_FU2) || (step_r == K_FU3) ||
                  (step_r == K_FU4);
  assign ft     = fade_u ? fx_r : fy_r;
  assign fa     = FB_W'({1'b0, ft}) * FB_W'(FADE_C1) - FB_W'(FADE_C2 * ONE_Q16);

  // Table read address per octave step
  always_comb begin
    ram_raddr = ix_r;
    case (step_r)
      K_FU1:   ram_raddr = ix_r;
      K_FU2:   ram_raddr = ix_r + IW'(1);
      K_FU3:   ram_raddr = px0_r + iy_r;
      K_FU4:   ram_raddr = px0_r + iy_r + IW'(1);
      K_FV1:   ram_raddr = px1_r + iy_r;
      K_FV2:   ram_raddr = px1_r + iy_r + IW'(1);
      default: ram_raddr = ix_r;
    endcase
  end

  // Shared multiplier operand selection
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;

  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == S_OCT) begin
      case (step_r)
        K_CX: begin
          ma = MA_W'(cx_r);
          mb = MB_W'({1'b0, freq_r});
        end
        K_CY: begin
          ma = MA_W'(cy_r);
          mb = MB_W'({1'b0, freq_r});
        end
        K_FU1, K_FV1: begin
          ma = MA_W'({1'b0, ft});
          mb = MB_W'(fa);
        end
        K_FU2, K_FV2: begin
          ma = MA_W'({1'b0, ft});
          mb = MB_W'({1'b0, ft});
        end
        K_FU3, K_FV3: begin
          ma = MA_W'({1'b0, prod_r[31:16]});
          mb = MB_W'({1'b0, ft});
        end
        K_FU4, K_FV4: begin
          ma = MA_W'({1'b0, prod_r[31:16]});
          mb = MB_W'(fb_r);
        end
        K_B0: begin
          ma = MA_W'(u_r);
          mb = MB_W'(DIFF_W'(g_ba_r) - DIFF_W'(g_aa_r));
        end
        K_B1: begin
          ma = MA_W'(u_r);
          mb = MB_W'(DIFF_W'(g_bb_r) - DIFF_W'(g_ab_r));
        end
        K_B3: begin
          ma = MA_W'(v_r);
          mb = MB_W'(DIFF_W'(r1_r) - DIFF_W'(r0_r));
        end
        K_NA: begin
          ma = MA_W'(n_r);
          mb = MB_W'({1'b0, amp_r});
        end
        K_AC: begin
          ma = MA_W'({1'b0, amp_r});
          mb = MB_W'({1'b0, cfg_pers_r});
        end
        K_AM: begin
          ma = MA_W'({1'b0, freq_r});
          mb = MB_W'({1'b0, cfg_lac_r});
        end
        default: begin
          ma = '0;
          mb = '0;
        end
      endcase
    end else if (state_r == S_W1) begin
      ma = MA_W'(ws_r);
      mb = MB_W'(ox_r);
    end else if (state_r == S_W2) begin
      ma = MA_W'(ws_r);
      mb = MB_W'(oy_r);
    end
  end

  // Normalised result of the finished fractal pass
  logic signed [NOISE_W-1:0] qv;
  logic signed [NOISE_W-1:0] qpos;
  logic [OCW-1:0]            noct;
  logic [ACC_W-1:0]          acc_mag;
  logic [ACC_W-1:0]          den;
  logic [ACC_W-1:0]          frq_hi;

  assign qpos    = NOISE_W'({1'b0, q_r});
  assign qv      = ovf_r ? (neg_r ? NOISE_MIN : NOISE_MAX) : (neg_r ? -qpos : qpos);
  assign noct    = (32'(cfg_oct_r) > MAX_OCTAVES) ? OCW'(MAX_OCTAVES) : OCW'(cfg_oct_r);
  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign den     = ACC_W'({tot_r, 2'b00});
  assign frq_hi  = ACC_W'(prod_r[PROD_W-1:12+FREQ_W]);

  // Next state and step
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_acc) begin
          state_nxt = (in_act == ACT_FRACTAL || in_act == ACT_WARP) ? S_INIT : S_PUT;
        end
      end
      S_INIT: begin
        step_nxt  = K_CX;
        state_nxt = (noct == '0) ? S_DIV0 : S_OCT;
      end
      S_OCT: begin
        if (step_r == K_FQ) begin
          step_nxt  = K_CX;
          state_nxt = (oct_r + OCW'(1) == noct_r) ? S_DIV0 : S_OCT;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_DIV0: state_nxt = (tot_r == '0) ? S_FIN : S_DIV1;
      S_DIV1: state_nxt = (cnt_r == '0) ? S_FIN : S_DIV1;
      S_FIN: begin
        unique case (ph_r)
          PH_OX:   state_nxt = S_INIT;
          PH_OY:   state_nxt = S_W1;
          default: state_nxt = S_PUT;
        endcase
      end
      S_W1: state_nxt = S_W2;
      S_W2: state_nxt = S_W3;
      S_W3: state_nxt = S_INIT;
      S_PUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= K_CX;
      ph_r         <= PH_OUT;
      oct_r        <= '0;
      noct_r       <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      cfg_oct_r    <= 4'd4;
      cfg_amp_r    <= AMP_W'(4096);
      cfg_freq_r   <= FREQ_W'(65536);
      cfg_pers_r   <= AMP_W'(32768);
      cfg_lac_r    <= AMP_W'(8192);
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_OCTAVES:   cfg_oct_r  <= cfg_wdata[3:0];
          CFG_BASE_AMP:  cfg_amp_r  <= cfg_wdata[AMP_W-1:0];
          CFG_BASE_FREQ: cfg_freq_r <= cfg_wdata[FREQ_W-1:0];
          CFG_PERSIST:   cfg_pers_r <= cfg_wdata[AMP_W-1:0];
          CFG_LACUN:     cfg_lac_r  <= cfg_wdata[AMP_W-1:0];
          default: ;
        endcase
      end

      // pass selection
      if (req_acc) begin
        ph_r <= (in_act == ACT_WARP) ? PH_OX : PH_OUT;
      end else if (state_r == S_FIN && ph_r == PH_OX) begin
        ph_r <= PH_OY;
      end else if (state_r == S_W3) begin
        ph_r <= PH_OUT;
      end

      // octave and divider counters
      if (state_r == S_INIT) begin
        oct_r  <= '0;
        noct_r <= noct;
      end else if (state_r == S_OCT && step_r == K_FQ) begin
        oct_r <= oct_r + OCW'(1);
      end
      if (state_r == S_DIV0) begin
        cnt_r <= CNT_W'(Q_BITS - 1);
      end else if (state_r == S_DIV1) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end

      // result register: load on hand-over, drop once taken
      if (state_r == S_PUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;

    // hold request fields and set the first sample point
    if (req_acc) begin
      x_r   <= in_x;
      y_r   <= in_y;
      ws_r  <= in_ws;
      wxy_r <= in_wxy;
      wyy_r <= in_wyy;
      res_r <= '0;
      ack_r <= (in_act == ACT_WRITE);
      if (in_act == ACT_WARP) begin
        cx_r <= sat_coord(SUM_W'(in_x) + SUM_W'(in_wxx));
        cy_r <= sat_coord(SUM_W'(in_y) + SUM_W'(in_wyx));
      end else begin
        cx_r <= in_x;
        cy_r <= in_y;
      end
    end

    case (state_r)
      S_INIT: begin
        amp_r  <= cfg_amp_r;
        freq_r <= cfg_freq_r;
        acc_r  <= '0;
        tot_r  <= '0;
      end
      S_OCT: begin
        case (step_r)
          K_CY: begin
            fx_r <= prod_r[31:16];
            ix_r <= prod_r[32 +: IW];
          end
          K_FU1: begin
            fy_r <= prod_r[31:16];
            iy_r <= prod_r[32 +: IW];
          end
          K_FU2: begin
            px0_r <= rd_idx;
            fb_r  <= FB_W'(prod_r >>> 16) + FB_W'(FADE_C3 * ONE_Q16);
          end
          K_FU3: px1_r  <= rd_idx;
          K_FU4: g_aa_r <= grad_dot(ram_rdata[2:0], fx0, fy0);
          K_FV1: begin
            g_ab_r <= grad_dot(ram_rdata[2:0], fx0, fy1);
            u_r    <= FADE_W'(prod_r >>> 16);
          end
          K_FV2: begin
            g_ba_r <= grad_dot(ram_rdata[2:0], fx1, fy0);
            fb_r   <= FB_W'(prod_r >>> 16) + FB_W'(FADE_C3 * ONE_Q16);
          end
          K_FV3: g_bb_r <= grad_dot(ram_rdata[2:0], fx1, fy1);
          K_B0:  v_r    <= FADE_W'(prod_r >>> 16);
          K_B1:  r0_r   <= g_aa_r + GRAD_W'(prod_r >>> 16);
          K_B2:  r1_r   <= g_ab_r + GRAD_W'(prod_r >>> 16);
          K_BN:  n_r    <= r0_r + GRAD_W'(prod_r >>> 16);
          K_AC: begin
            acc_r <= acc_r + ACC_W'(prod_r);
            tot_r <= tot_r + TOT_W'(amp_r);
          end
          K_AM: amp_r <= prod_r[31:16];
          K_FQ: freq_r <= (frq_hi != '0) ? FREQ_MAX : prod_r[12 +: FREQ_W];
          default: ;
        endcase
      end
      S_DIV0: begin
        neg_r <= (tot_r != '0) && acc_r[ACC_W-1];
        ovf_r <= (tot_r != '0) && (acc_mag >= (den << Q_BITS));
        rem_r <= acc_mag;
        dsh_r <= den << (Q_BITS - 1);
        q_r   <= '0;
      end
      S_DIV1: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[Q_BITS-2:0], 1'b1};
        end else begin
          q_r <= {q_r[Q_BITS-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      S_FIN: begin
        case (ph_r)
          PH_OX: begin
            ox_r <= qv;
            cx_r <= sat_coord(SUM_W'(x_r) + SUM_W'(wxy_r));
            cy_r <= sat_coord(SUM_W'(y_r) + SUM_W'(wyy_r));
          end
          PH_OY:   oy_r  <= qv;
          default: res_r <= qv;
        endcase
      end
      S_W2: cx_r <= sat_coord(SUM_W'(x_r) + SUM_W'(prod_r >>> 14));
      S_W3: cy_r <= sat_coord(SUM_W'(y_r) + SUM_W'(prod_r >>> 14));
      S_PUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_noise_r <= res_r;
          out_ack_r   <= ack_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_noise_r;
  assign out_tuser  = out_ack_r;

endmodule

### rtl/core/fpn_checker.sv
// fpn_checker: port-level assertions for the fractal Perlin noise core.
// Depends on fpn_pkg; bound to fractal_perlin_noise_2d at the end of this file.
module fpn_checker import fpn_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [NOISE_W-1:0] out_tdata,
  input logic [0:0]         out_tuser
);

  // Reset idles the core and empties the result register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> in_tready && !out_tvalid)
    else $error("core not idle after reset");

  // One request in flight: an accepted request closes the input
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  // Table writes acknowledge with a zero noise value
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("write acknowledge carries noise");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind fractal_perlin_noise_2d fpn_checker u_fpn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### test/tb_fractal_perlin_noise_2d.sv
// Self-checking testbench for fractal_perlin_noise_2d: table loads, fractal and warped noise.
// Depends on fpn_pkg and the RTL top level; holds its own fixed-point noise predictor.
`timescale 1ns / 100ps

module tb_fractal_perlin_noise_2d;
  import fpn_pkg::*;

  localparam int TBL_SIZE    = 256;
  localparam int OCT_LIMIT   = 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_LEN    = 2500;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic [7:0]       idx;
    logic [7:0]       val;
    coord_t           x, y, ws, oxx, oyx, oxy, oyy;
  } noise_req_t;

  typedef struct {
    logic [NOISE_W-1:0] noise;
    logic               ack;
  } noise_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ACT_W-1:0] in_tuser = '0;
  logic [239:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [NOISE_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  fractal_perlin_noise_2d DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [7:0] perm_copy [TBL_SIZE];
  longint oct_cfg = 4, amp_cfg = 4096, freq_cfg = 65536, pers_cfg = 32768, lac_cfg = 8192;

  noise_req_t pending_reqs[$];
  noise_res_t noise_expected[$];
  int  fail_count = 0;
  int  results_seen = 0;
  longint cycle_count = 0;

  function automatic longint wrap_tbl(longint i);
    return i & (TBL_SIZE - 1);
  endfunction

  function automatic longint perm_at(longint i);
    return perm_copy[wrap_tbl(i)] % TBL_SIZE;
  endfunction

  function automatic longint grad_of(longint h, longint gx, longint gy);
    case (h & 7)
      0: return gx + gy;
      1: return gy - gx;
      2: return gx - gy;
      3: return -gx - gy;
      4: return gx;
      5: return -gx;
      6: return gy;
      default: return -gy;
    endcase
  endfunction

  function automatic longint fade_of(longint t);
    longint a, b, t2, t3;
    a  = 6 * t - 15 * ONE_Q16;
    b  = ((t * a) >>> 16) + 10 * ONE_Q16;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    return (t3 * b) >>> 16;
  endfunction

  function automatic longint lerp_of(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint gradient_sample(longint px, longint py);
    longint ix, iy, fx, fy, xi, yi, p0, p1, aa, ab, ba, bb, u, v, r0, r1;
    ix = px >>> 16;
    iy = py >>> 16;
    fx = px - ix * ONE_Q16;
    fy = py - iy * ONE_Q16;
    xi = wrap_tbl(ix);
    yi = wrap_tbl(iy);
    p0 = perm_at(xi);
    p1 = perm_at(xi + 1);
    aa = perm_at(p0 + yi);
    ab = perm_at(p0 + yi + 1);
    ba = perm_at(p1 + yi);
    bb = perm_at(p1 + yi + 1);
    u  = fade_of(fx);
    v  = fade_of(fy);
    r0 = lerp_of(grad_of(aa, fx, fy), grad_of(ba, fx - ONE_Q16, fy), u);
    r1 = lerp_of(grad_of(ab, fx, fy - ONE_Q16), grad_of(bb, fx - ONE_Q16, fy - ONE_Q16), u);
    return lerp_of(r0, r1, v);
  endfunction

  function automatic longint fbm_of(longint x, longint y);
    longint n_oct, amp, freq, acc, total, q;
    n_oct = (oct_cfg > OCT_LIMIT) ? OCT_LIMIT : oct_cfg;
    amp = amp_cfg;
    freq = freq_cfg;
    acc = 0;
    total = 0;
    for (longint i = 0; i < n_oct; i++) begin
      acc   += gradient_sample((x * freq) >>> 16, (y * freq) >>> 16) * amp;
      total += amp;
      amp  = (amp * pers_cfg) >> 16;
      freq = (freq * lac_cfg) >> 12;
      if (freq > 16777215) freq = 16777215;
    end
    if (total == 0) return 0;
    q = acc / (total * 4);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Work out the result of one accepted request and update the table copy
  function automatic noise_res_t predict_noise(noise_req_t r);
    noise_res_t res;
    longint ox, oy, dx, dy;
    res.noise = '0;
    res.ack = 1'b0;
    case (r.act)
      ACT_WRITE: begin
        perm_copy[r.idx] = r.val;
        res.ack = 1'b1;
      end
      ACT_FRACTAL: res.noise = NOISE_W'(fbm_of(r.x, r.y));
      ACT_WARP: begin
        ox = fbm_of(clamp32(longint'(r.x) + r.oxx), clamp32(longint'(r.y) + r.oyx));
        oy = fbm_of(clamp32(longint'(r.x) + r.oxy), clamp32(longint'(r.y) + r.oyy));
        dx = clamp32(longint'(r.x) + ((longint'(r.ws) * ox) >>> 14));
        dy = clamp32(longint'(r.y) + ((longint'(r.ws) * oy) >>> 14));
        res.noise = NOISE_W'(fbm_of(dx, dy));
      end
      default: ;
    endcase
    return res;
  endfunction

  // Request driver: bursts of random length with random gaps
  noise_req_t cur_req;
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) noise_expected.push_back(predict_noise(cur_req));
      if (in_tvalid && !in_tready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_req.act;
        in_tdata <= {cur_req.oyy, cur_req.oxy, cur_req.oyx, cur_req.oxx, cur_req.ws,
                     cur_req.y, cur_req.x, cur_req.val, cur_req.idx};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern, one long hold-off, compare with the oldest expectation
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  noise_res_t want;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected result noise=%h ack=%b", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = noise_expected.pop_front();
          if (out_tdata !== want.noise || out_tuser[0] !== want.ack) begin
            $display("%0t: mismatch expected noise=%h ack=%b actual noise=%h ack=%b",
                     $time, want.noise, want.ack, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (!hold_done && results_seen == 300) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3, 4: return $urandom;
      default: return coord_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic noise_req_t make_req(logic [ACT_W-1:0] act);
    noise_req_t r;
    r.act = act;
    r.idx = 8'($urandom);
    r.val = 8'($urandom);
    r.x = pick_coord();
    r.y = pick_coord();
    r.ws = pick_coord();
    r.oxx = pick_coord();
    r.oyx = pick_coord();
    r.oxy = pick_coord();
    r.oyy = pick_coord();
    return r;
  endfunction

  task automatic add_random(int n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 15) pending_reqs.push_back(make_req(ACT_WRITE));
      else if (k < 20) pending_reqs.push_back(make_req(ACT_NONE));
      else if (k < 65) pending_reqs.push_back(make_req(ACT_FRACTAL));
      else pending_reqs.push_back(make_req(ACT_WARP));
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || noise_expected.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_OCTAVES:   oct_cfg = val & 64'hF;
      CFG_BASE_AMP:  amp_cfg = val & 64'hFFFF;
      CFG_BASE_FREQ: freq_cfg = val & 64'hFF_FFFF;
      CFG_PERSIST:   pers_cfg = val & 64'hFFFF;
      CFG_LACUN:     lac_cfg = val & 64'hFFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(longint o, longint a, longint f, longint p, longint l);
    write_cfg(CFG_OCTAVES, o);
    write_cfg(CFG_BASE_AMP, a);
    write_cfg(CFG_BASE_FREQ, f);
    write_cfg(CFG_PERSIST, p);
    write_cfg(CFG_LACUN, l);
  endtask

  initial begin
    noise_req_t r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Load the whole table before any noise request reads it
    for (int i = 0; i < TBL_SIZE; i++) begin
      r = make_req(ACT_WRITE);
      r.idx = 8'(i);
      if (i == 0) r.val = 8'h00;
      if (i == TBL_SIZE - 1) r.val = 8'hFF;
      pending_reqs.push_back(r);
    end

    // Directed: origin, lattice edges, coordinate extremes, unused action, saturating warps
    r = make_req(ACT_FRACTAL); r.x = 0; r.y = 0; pending_reqs.push_back(r);
    r = make_req(ACT_FRACTAL); r.x = 32'h0000_FFFF; r.y = 32'hFFFF_0001;
    pending_reqs.push_back(r);
    r = make_req(ACT_FRACTAL); r.x = COORD_MIN; r.y = COORD_MAX; pending_reqs.push_back(r);
    r = make_req(ACT_FRACTAL); r.x = COORD_MAX; r.y = COORD_MIN; pending_reqs.push_back(r);
    r = make_req(ACT_NONE); r.x = COORD_MAX; pending_reqs.push_back(r);
    r = make_req(ACT_WARP); r.x = COORD_MAX; r.y = COORD_MAX; r.ws = COORD_MAX;
    r.oxx = COORD_MAX; r.oyx = COORD_MAX; r.oxy = COORD_MAX; r.oyy = COORD_MAX;
    pending_reqs.push_back(r);
    r = make_req(ACT_WARP); r.x = COORD_MIN; r.y = COORD_MIN; r.ws = COORD_MIN;
    r.oxx = COORD_MIN; r.oyx = COORD_MIN; r.oxy = COORD_MIN; r.oyy = COORD_MIN;
    pending_reqs.push_back(r);
    r = make_req(ACT_WARP); r.ws = 0; pending_reqs.push_back(r);
    r = make_req(ACT_WRITE); r.idx = 8'hFF; r.val = 8'h00; pending_reqs.push_back(r);
    r = make_req(ACT_WRITE); r.idx = 8'h00; r.val = 8'hFF; pending_reqs.push_back(r);
    r = make_req(ACT_FRACTAL); r.x = 32'h00FF_8000; r.y = 32'h0000_8000;
    pending_reqs.push_back(r);
    add_random(30);
    wait_idle();

    // Minimum factors: one octave, lowest nonzero amplitude and frequency, zero persistence
    set_all(1, 1, 1, 0, 0);
    add_random(40);
    wait_idle();

    // Maximum of every register but the octave count, frequency saturates
    set_all(8, 65535, 16777215, 65535, 65535);
    add_random(40);
    wait_idle();

    // Octave count above the limit saturates
    set_all(15, 4096, 196608, 40000, 8192);
    add_random(40);
    wait_idle();

    // No octaves, then zero amplitude: both give zero
    set_all(0, 4096, 65536, 32768, 8192);
    add_random(15);
    wait_idle();
    set_all(2, 0, 65536, 32768, 8192);
    add_random(15);
    wait_idle();

    // Random settings with one to four octaves
    for (int ph = 0; ph < 4; ph++) begin
      set_all($urandom_range(1, 4), $urandom_range(1, 65535), $urandom_range(1, 24'hFFFFFF),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
      add_random(40);
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && noise_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
